// ===== design/idt_pkg.sv =====
// Shared types, codes and capability helpers of the IOMMU domain table.
// No dependencies; imported by the interfaces, the controller and the top level.
`default_nettype none
package idt_pkg;

    localparam int PAGE_BITS  = 12;
    localparam int IN_ADDR_W  = 52;
    localparam int ROOT_W     = IN_ADDR_W - PAGE_BITS;
    localparam int ATTR_W     = 15;
    localparam int WIDTH_BASE = 30;
    localparam int LEVEL_STEP = 9;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_GET   = 2'd1,
        OP_PUT   = 2'd2,
        OP_FREE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_EXISTS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_BUSY     = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_INCOMPAT = 3'd6,
        ST_WARN     = 3'd7
    } status_t;

    typedef struct packed {
        op_t                    operation;
        logic [IN_ADDR_W-1:0]   root_address;
        logic [15:0]            domain_id;
        logic [2:0]             width_code;
        logic                   first_level;
        logic                   iommu_present;
        logic [5:0]             iommu_flags;
        logic [4:0]             supported_widths;
        logic [6:0]             max_address_width;
        logic [3:0]             superpage_support;
        logic [6:0]             handle_in;
    } req_t;

    // Usable iova width in bits, zero when the request does not suit the IOMMU.
    function automatic logic [6:0] iova_width(input logic [5:0] flags,
                                              input logic [4:0] widths,
                                              input logic [6:0] mgaw,
                                              input logic       fl,
                                              input logic [2:0] code);
        logic [6:0] w;
        logic       bad;
        bad = 1'b0;
        if (code != 3'd2 && code != 3'd3)
            bad = 1'b1;
        else if (fl)
            bad = !flags[0] || !flags[1] || (code == 3'd3 && !flags[3]);
        else if (flags[0] && !flags[2])
            bad = 1'b1;
        else
            bad = !widths[code];
        w = (code == 3'd3) ? 7'(WIDTH_BASE + 3 * LEVEL_STEP)
                           : 7'(WIDTH_BASE + 2 * LEVEL_STEP);
        if (mgaw < w)
            w = mgaw;
        if (fl && w != 7'd0)
            w = w - 7'd1;
        if (bad || w < 7'(PAGE_BITS))
            w = 7'd0;
        return w;
    endfunction

    // Page-size mask, bit0 4K, bit1 2M, bit2 1G.
    function automatic logic [2:0] pgsize_mask(input logic [5:0] flags,
                                               input logic [3:0] sp,
                                               input logic       fl);
        logic [2:0] m;
        m = 3'b011;
        if (fl)
        begin
            if (flags[4])
                m[2] = 1'b1;
        end
        else
        begin
            if (!sp[0])
                m[1] = 1'b0;
            if (sp[1])
                m[2] = 1'b1;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== design/idt_req_if.sv =====
// Request channel of the domain table: valid/ready plus one request beat.
// Depends on idt_pkg for the operation type.
`default_nettype none
interface idt_req_if;
    import idt_pkg::*;
    logic             valid;
    logic             ready;
    op_t              operation;
    logic [51:0]      root_address;
    logic [15:0]      domain_id;
    logic [2:0]       width_code;
    logic             first_level;
    logic             iommu_present;
    logic [5:0]       iommu_flags;
    logic [4:0]       supported_widths;
    logic [6:0]       max_address_width;
    logic [3:0]       superpage_support;
    logic [6:0]       handle_in;

    modport source (output valid, operation, root_address, domain_id, width_code,
                    first_level, iommu_present, iommu_flags, supported_widths,
                    max_address_width, superpage_support, handle_in,
                    input ready);
    modport sink (input valid, operation, root_address, domain_id, width_code,
                  first_level, iommu_present, iommu_flags, supported_widths,
                  max_address_width, superpage_support, handle_in,
                  output ready);
endinterface
`default_nettype wire

// ===== design/idt_rsp_if.sv =====
// Response channel of the domain table: valid/ready plus status and handle.
// Depends on idt_pkg for the status type.
`default_nettype none
interface idt_rsp_if;
    import idt_pkg::*;
    logic       valid;
    logic       ready;
    status_t    status;
    logic [6:0] handle;

    modport source (output valid, status, handle, input ready);
    modport sink (input valid, status, handle, output ready);
endinterface
`default_nettype wire

// ===== design/iommu_domain_table_unit.sv =====
// Alloc, get by root and free scan the slots one per cycle; put reads its one
// slot directly, and immediate answers skip the scan.
// Throughput: one beat at a time, set by the single-read-port slot RAM scan.
// Reset: asynchronous, clears used bits and handshake state; registers go to
// passthrough width code 2 and passthrough id 1. No clearing pass.
`default_nettype none
module iommu_domain_table_unit #(
    parameter int MAX_DOMAINS = 64,
    parameter int ADDR_BITS   = 52,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    idt_req_if.sink          req,
    idt_rsp_if.source        rsp,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import idt_pkg::*;

    localparam int AW = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
    localparam int EW = ROOT_W + ATTR_W + COUNT_BITS;
    localparam logic CFG_AGAW  = 1'b0;
    localparam logic CFG_PT_ID = 1'b1;

    logic [2:0]    pt_agaw_reg;
    logic [15:0]   pt_id_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_agaw_reg <= 3'd2;
            pt_id_reg   <= 16'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_AGAW)
                pt_agaw_reg <= cfg_wdata[2:0];
            if (cfg_index == CFG_PT_ID)
                pt_id_reg <= cfg_wdata;
        end
    end

    idt_ctrl #(
        .MAX_DOMAINS (MAX_DOMAINS),
        .ADDR_BITS   (ADDR_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .AW          (AW),
        .EW          (EW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .pt_agaw      (pt_agaw_reg),
        .pt_domain_id (pt_id_reg),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    idt_ram #(
        .DEPTH (MAX_DOMAINS),
        .WIDTH (EW),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

`ifndef ASSERT_OFF
    a_handle_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.handle == 7'd0)
        else $error("handle not zero on error status");

    a_handle_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> 32'(rsp.handle) <= 32'(MAX_DOMAINS))
        else $error("handle out of range");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("second beat accepted while busy");
`endif
endmodule
`default_nettype wire

// ===== design/idt_ram.sv =====
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Holds the per-slot root key, attributes and reference count. No dependencies.
`default_nettype none
module idt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 71,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/idt_ctrl.sv =====
// Sequencer of the domain table: slot scan, read-modify-write of one entry,
// used bits and the response register. Depends on idt_pkg and both channel interfaces.
`default_nettype none
module idt_ctrl #(
    parameter int MAX_DOMAINS = 64,
    parameter int ADDR_BITS   = 52,
    parameter int COUNT_BITS  = 16,
    parameter int AW          = 6,
    parameter int EW          = 71
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    idt_req_if.sink            req,
    idt_rsp_if.source          rsp,
    input  wire logic [2:0]    pt_agaw,
    input  wire logic [15:0]   pt_domain_id,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [EW-1:0]      mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  wire logic [EW-1:0] mem_rdata
);
    import idt_pkg::*;

    localparam logic [AW-1:0]         LAST      = AW'(MAX_DOMAINS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [IN_ADDR_W-1:0]  HI_MASK   =
        ~((IN_ADDR_W'(1) << ADDR_BITS) - IN_ADDR_W'(1));
    localparam logic [31:0]           PT_HANDLE = 32'(MAX_DOMAINS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_PUTRD = 5'b00100,
        S_ACT   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    req_t                   req_reg, req_next;
    logic [AW:0]            cnt_reg, cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                   hit_reg, hit_next;
    logic [AW-1:0]          hit_idx_reg, hit_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [AW-1:0]          free_idx_reg, free_idx_next;
    logic [MAX_DOMAINS-1:0] used_reg, used_next;
    status_t                res_status_reg, res_status_next;
    logic [6:0]             res_handle_reg, res_handle_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [6:0]             out_handle_reg, out_handle_next;

    logic [ROOT_W-1:0]      e_root;
    logic [ATTR_W-1:0]      e_attr;
    logic [COUNT_BITS-1:0]  e_count, cnt_eff;
    logic [ROOT_W-1:0]      key;
    logic                   scan_hit;
    logic                   rd_en;
    logic [6:0]             w_req, w_slot;
    logic [7:0]             pt_widths;
    logic                   compat;

    assign e_root  = mem_rdata[EW-1 -: ROOT_W];
    assign e_attr  = mem_rdata[COUNT_BITS +: ATTR_W];
    assign e_count = mem_rdata[COUNT_BITS-1:0];
    assign cnt_eff = used_reg[hit_idx_reg] ? e_count : '0;
    assign key     = req_reg.root_address[IN_ADDR_W-1:PAGE_BITS];

    assign scan_hit = cmp_vld_reg && used_reg[cmp_idx_reg] && (e_root == key);
    assign rd_en    = !scan_hit && (32'(cnt_reg) < 32'(MAX_DOMAINS));

    assign w_req  = iova_width(req_reg.iommu_flags, req_reg.supported_widths,
                               req_reg.max_address_width, req_reg.first_level,
                               req_reg.width_code);
    assign w_slot = iova_width(req_reg.iommu_flags, req_reg.supported_widths,
                               req_reg.max_address_width, e_attr[3], e_attr[2:0]);
    assign compat = (w_slot != 7'd0) && (e_attr[10:4] <= w_slot) &&
                    ((e_attr[13:11] & ~pgsize_mask(req_reg.iommu_flags,
                        req_reg.superpage_support, e_attr[3])) == 3'd0) &&
                    (req_reg.iommu_flags[5] || e_attr[14]);
    assign pt_widths = {3'b000, req.supported_widths};

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.handle = out_handle_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        mem_we    = 1'b0;
        mem_waddr = hit_idx_reg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = cnt_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next = '{req.operation, req.root_address, req.domain_id,
                                 req.width_code, req.first_level, req.iommu_present,
                                 req.iommu_flags, req.supported_widths,
                                 req.max_address_width, req.superpage_support,
                                 req.handle_in};
                    cnt_next        = '0;
                    cmp_vld_next    = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    res_status_next = ST_OK;
                    res_handle_next = 7'd0;
                    state_next      = S_SCAN;
                    unique case (req.operation)
                        OP_ALLOC:
                        begin
                            if (!req.iommu_present || req.root_address == '0 ||
                                req.root_address[PAGE_BITS-1:0] != '0 ||
                                (req.root_address & HI_MASK) != '0 ||
                                iova_width(req.iommu_flags, req.supported_widths,
                                           req.max_address_width, req.first_level,
                                           req.width_code) == 7'd0)
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_DONE;
                            end
                        end
                        OP_GET:
                        begin
                            if (req.domain_id == pt_domain_id)
                            begin
                                state_next = S_DONE;
                                if ((!req.iommu_flags[0] || req.iommu_flags[2]) &&
                                    pt_widths[pt_agaw])
                                    res_handle_next = 7'(MAX_DOMAINS);
                                else
                                    res_status_next = ST_INCOMPAT;
                            end
                            else if (req.root_address[PAGE_BITS-1:0] != '0)
                            begin
                                res_status_next = ST_NOTFOUND;
                                state_next      = S_DONE;
                            end
                        end
                        OP_PUT:
                        begin
                            if (32'(req.handle_in) == PT_HANDLE)
                            begin
                                res_handle_next = req.handle_in;
                                state_next      = S_DONE;
                            end
                            else if (32'(req.handle_in) > PT_HANDLE)
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                hit_idx_next = req.handle_in[AW-1:0];
                                state_next   = S_PUTRD;
                            end
                        end
                        OP_FREE:
                        begin
                            if (req.root_address[PAGE_BITS-1:0] != '0)
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                // read slot cnt while comparing the previously read slot
                if (scan_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    state_next   = S_ACT;
                end
                else
                begin
                    if (cmp_vld_reg && !used_reg[cmp_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    mem_re       = rd_en;
                    cmp_vld_next = rd_en;
                    cmp_idx_next = cnt_reg[AW-1:0];
                    if (rd_en)
                        cnt_next = cnt_reg + 1'b1;
                    if (cmp_vld_reg && cmp_idx_reg == LAST)
                        state_next = S_ACT;
                end
            end
            S_PUTRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = hit_idx_reg;
                state_next = S_ACT;
            end
            S_ACT:
            begin
                state_next = S_DONE;
                unique case (req_reg.operation)
                    OP_ALLOC:
                    begin
                        if (hit_reg)
                            res_status_next = ST_EXISTS;
                        else if (!free_found_reg)
                            res_status_next = ST_FULL;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = free_idx_reg;
                            mem_wdata = {key, !req_reg.iommu_flags[5],
                                         pgsize_mask(req_reg.iommu_flags,
                                                     req_reg.superpage_support,
                                                     req_reg.first_level),
                                         w_req, req_reg.first_level,
                                         req_reg.width_code,
                                         COUNT_BITS'(1)};
                            used_next[free_idx_reg] = 1'b1;
                            res_handle_next = 7'(free_idx_reg);
                        end
                    end
                    OP_GET:
                    begin
                        if (!hit_reg)
                            res_status_next = ST_NOTFOUND;
                        else if (e_count == '0 || e_count == COUNT_MAX)
                            res_status_next = ST_WARN;
                        else if (!compat)
                            res_status_next = ST_INCOMPAT;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {e_root, e_attr, e_count + 1'b1};
                            res_handle_next = 7'(hit_idx_reg);
                        end
                    end
                    OP_PUT:
                    begin
                        if (cnt_eff != '0)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {e_root, e_attr, cnt_eff - 1'b1};
                        end
                        if (cnt_eff <= COUNT_BITS'(1))
                            res_status_next = ST_WARN;
                        else
                            res_handle_next = 7'(hit_idx_reg);
                    end
                    OP_FREE:
                    begin
                        if (!hit_reg)
                            res_status_next = ST_INVALID;
                        else if (e_count != COUNT_BITS'(1))
                            res_status_next = ST_BUSY;
                        else
                        begin
                            used_next[hit_idx_reg] = 1'b0;
                            res_handle_next = 7'(hit_idx_reg);
                        end
                    end
                    default: ;
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = (res_status_reg == ST_OK) ? res_handle_reg : 7'd0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            out_valid_reg  <= out_valid_next;
            cmp_vld_reg    <= cmp_vld_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
    end
endmodule
`default_nettype wire

// ===== dv/idt_domain_checker.sv =====
// Watches the request, response and register ports of the domain table and predicts each answer.
// Depends on idt_pkg and on the idt_req_if and idt_rsp_if interfaces.
`default_nettype none
module idt_domain_checker #(
    parameter int SLOTS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    idt_req_if               req,
    idt_rsp_if               rsp,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import idt_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic CFG_PT_AGAW = 1'b0;
    localparam logic CFG_PT_ID   = 1'b1;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    typedef struct packed {
        status_t    status;
        logic [6:0] handle;
    } answer_t;

    // per-slot domain record
    logic               used    [SLOTS];
    logic [ROOT_W-1:0]  root_of [SLOTS];
    logic [2:0]         code_of [SLOTS];
    logic               fl_of   [SLOTS];
    logic [6:0]         bits_of [SLOTS];
    logic [2:0]         pg_of   [SLOTS];
    logic               flush_of[SLOTS];
    logic [15:0]        refs    [SLOTS];
    logic [2:0]         pt_agaw;
    logic [15:0]        pt_id;
    answer_t            answers_due[$];

    function automatic logic [6:0] usable_bits(logic [5:0] flags, logic [4:0] widths,
                                               logic [6:0] mgaw, logic fl, logic [2:0] code);
        int w;
        if (code != 3'd2 && code != 3'd3)
            return 7'd0;
        if (fl)
        begin
            if (!flags[0] || !flags[1] || (code == 3'd3 && !flags[3]))
                return 7'd0;
        end
        else if (flags[0] && !flags[2])
            return 7'd0;
        else if (!widths[code])
            return 7'd0;
        w = 30 + int'(code) * 9;
        if (int'(mgaw) < w)
            w = int'(mgaw);
        if (fl)
            w = (w == 0) ? 0 : w - 1;
        if (w < 12)
            return 7'd0;
        return 7'(w);
    endfunction

    function automatic logic [2:0] page_sizes(logic [5:0] flags, logic [3:0] sp, logic fl);
        logic [2:0] m;
        m = 3'b011;
        if (fl)
            m[2] = flags[4];
        else
        begin
            m[1] = sp[0];
            m[2] = sp[1];
        end
        return m;
    endfunction

    function automatic int slot_of_root(logic [IN_ADDR_W-1:0] root);
        if (root[PAGE_BITS-1:0] != '0)
            return -1;
        for (int i = 0; i < SLOTS; i++)
            if (used[i] && root_of[i] == root[IN_ADDR_W-1:PAGE_BITS])
                return i;
        return -1;
    endfunction

    function automatic answer_t serve_request(req_t r);
        answer_t    a;
        int         s;
        logic [6:0] w;
        logic [15:0] old;
        a.status = ST_OK;
        a.handle = 7'd0;
        case (r.operation)
            OP_ALLOC:
            begin
                w = usable_bits(r.iommu_flags, r.supported_widths, r.max_address_width,
                                r.first_level, r.width_code);
                if (!r.iommu_present || r.root_address == '0
                    || r.root_address[PAGE_BITS-1:0] != '0 || w == 7'd0)
                    a.status = ST_INVALID;
                else if (slot_of_root(r.root_address) >= 0)
                    a.status = ST_EXISTS;
                else
                begin
                    s = 0;
                    while (s < SLOTS && used[s])
                        s++;
                    if (s >= SLOTS)
                        a.status = ST_FULL;
                    else
                    begin
                        used[s]     = 1'b1;
                        root_of[s]  = r.root_address[IN_ADDR_W-1:PAGE_BITS];
                        code_of[s]  = r.width_code;
                        fl_of[s]    = r.first_level;
                        bits_of[s]  = w;
                        pg_of[s]    = page_sizes(r.iommu_flags, r.superpage_support,
                                                 r.first_level);
                        flush_of[s] = !r.iommu_flags[5];
                        refs[s]     = 16'd1;
                        a.handle    = 7'(s);
                    end
                end
            end
            OP_GET:
            begin
                if (r.domain_id == pt_id)
                begin
                    if ((!r.iommu_flags[0] || r.iommu_flags[2])
                        && pt_agaw < 3'd5 && r.supported_widths[pt_agaw])
                        a.handle = 7'(SLOTS);
                    else
                        a.status = ST_INCOMPAT;
                end
                else
                begin
                    s = slot_of_root(r.root_address);
                    if (s < 0)
                        a.status = ST_NOTFOUND;
                    else if (refs[s] == 16'd0 || refs[s] == COUNT_TOP)
                        a.status = ST_WARN;
                    else
                    begin
                        w = usable_bits(r.iommu_flags, r.supported_widths,
                                        r.max_address_width, fl_of[s], code_of[s]);
                        // the reference only sticks when the domain suits this IOMMU
                        if (w != 7'd0 && bits_of[s] <= w
                            && (pg_of[s] & ~page_sizes(r.iommu_flags, r.superpage_support,
                                                       fl_of[s])) == 3'd0
                            && (r.iommu_flags[5] || flush_of[s]))
                        begin
                            refs[s]  = refs[s] + 16'd1;
                            a.handle = 7'(s);
                        end
                        else
                            a.status = ST_INCOMPAT;
                    end
                end
            end
            OP_PUT:
            begin
                if (int'(r.handle_in) == SLOTS)
                    a.handle = r.handle_in;
                else if (int'(r.handle_in) > SLOTS)
                    a.status = ST_INVALID;
                else
                begin
                    old = refs[r.handle_in[SW-1:0]];
                    if (old != 16'd0)
                        refs[r.handle_in[SW-1:0]] = old - 16'd1;
                    if (old <= 16'd1)
                        a.status = ST_WARN;
                    else
                        a.handle = r.handle_in;
                end
            end
            default:
            begin
                s = slot_of_root(r.root_address);
                if (s < 0)
                    a.status = ST_INVALID;
                else if (refs[s] != 16'd1)
                    a.status = ST_BUSY;
                else
                begin
                    used[s]  = 1'b0;
                    refs[s]  = 16'd0;
                    a.handle = 7'(s);
                end
            end
        endcase
        return a;
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic req_t req_beat();
        req_t r;
        r.operation         = req.operation;
        r.root_address      = req.root_address;
        r.domain_id         = req.domain_id;
        r.width_code        = req.width_code;
        r.first_level       = req.first_level;
        r.iommu_present     = req.iommu_present;
        r.iommu_flags       = req.iommu_flags;
        r.supported_widths  = req.supported_widths;
        r.max_address_width = req.max_address_width;
        r.superpage_support = req.superpage_support;
        r.handle_in         = req.handle_in;
        return r;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                used[i] = 1'b0;
                refs[i] = 16'd0;
            end
            pt_agaw = 3'd2;
            pt_id   = 16'd1;
            answers_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PT_AGAW)
                    pt_agaw = cfg_wdata[2:0];
                else
                    pt_id = cfg_wdata;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                    report("unexpected beat, status", 8'(rsp.status), 8'hFF);
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.status !== want.status)
                        report("status", 8'(rsp.status), 8'(want.status));
                    if (rsp.handle !== want.handle)
                        report("handle", 8'(rsp.handle), 8'(want.handle));
                end
            end
            if (req.valid && req.ready)
                answers_due.push_back(serve_request(req_beat()));
        end
        pending = answers_due.size();
    end
endmodule
`default_nettype wire

// ===== dv/tb_iommu_domain_table_unit.sv =====
// Stimulus and verdict for iommu_domain_table_unit; checking lives in idt_domain_checker.
// Depends on idt_pkg, idt_req_if, idt_rsp_if, the block and the checker.
`default_nettype none
module tb_iommu_domain_table_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import idt_pkg::*;

    localparam int  ROOT_POOL   = 80;
    localparam int  CYCLE_LIMIT = 600000;
    localparam logic CFG_PT_AGAW = 1'b0;
    localparam logic CFG_PT_ID   = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        calm = 1'b0;
    int          errors, pending;
    int          cycles = 0;
    int          stall_left = 0;
    logic [15:0] pt_id = 16'd1;
    logic [IN_ADDR_W-1:0] roots[ROOT_POOL];

    idt_req_if req();
    idt_rsp_if rsp();

    iommu_domain_table_unit dut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    idt_domain_checker u_checker (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("iommu_domain_table_unit verification failed");
            $finish;
        end
    end

    // response side back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp.ready = 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = int'($urandom_range(0, 10));
            rsp.ready = 1'b0;
        end
        else
            rsp.ready = 1'b1;
    end

    function automatic req_t base_item(op_t op, logic [IN_ADDR_W-1:0] root);
        req_t r;
        r.operation         = op;
        r.root_address      = root;
        r.domain_id         = 16'h8000;
        r.width_code        = 3'd3;
        r.first_level       = 1'b0;
        r.iommu_present     = 1'b1;
        r.iommu_flags       = 6'b101111;
        r.supported_widths  = 5'b01100;
        r.max_address_width = 7'd57;
        r.superpage_support = 4'b0011;
        r.handle_in         = 7'd0;
        return r;
    endfunction

    function automatic req_t random_item();
        req_t r;
        int   kind;
        int   pick;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        r = base_item(pick < 35 ? OP_ALLOC : pick < 65 ? OP_GET : pick < 85 ? OP_PUT : OP_FREE,
                      roots[$urandom_range(0, ROOT_POOL - 1)]);
        if (kind < 10)
        begin
            r.operation         = op_t'($urandom_range(0, 3));
            r.root_address      = IN_ADDR_W'({$urandom(), $urandom()});
            r.domain_id         = 16'($urandom());
            r.width_code        = 3'($urandom());
            r.first_level       = 1'($urandom());
            r.iommu_present     = 1'($urandom());
            r.iommu_flags       = 6'($urandom());
            r.supported_widths  = 5'($urandom());
            r.max_address_width = 7'($urandom());
            r.superpage_support = 4'($urandom());
            r.handle_in         = 7'($urandom());
            return r;
        end
        r.iommu_flags = 6'b100111 | 6'($urandom_range(0, 3) << 3);
        if ($urandom_range(0, 4) == 0)
            r.iommu_flags = 6'($urandom());
        if ($urandom_range(0, 4) == 0)
            r.supported_widths = 5'($urandom());
        r.max_address_width = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(1, 64)) : 7'd57;
        r.superpage_support = 4'($urandom());
        r.width_code        = ($urandom_range(0, 9) == 0) ? 3'($urandom()) :
                              3'($urandom_range(2, 3));
        r.first_level       = 1'($urandom());
        r.domain_id         = ($urandom_range(0, 6) == 0) ? pt_id : 16'($urandom());
        pick = $urandom_range(0, 9);
        r.handle_in = (pick < 8) ? 7'($urandom_range(0, 15)) :
                      (pick < 9) ? 7'($urandom_range(0, 63)) : 7'($urandom_range(64, 127));
        return r;
    endfunction

    task automatic send(req_t r);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req.operation         = r.operation;
        req.root_address      = r.root_address;
        req.domain_id         = r.domain_id;
        req.width_code        = r.width_code;
        req.first_level       = r.first_level;
        req.iommu_present     = r.iommu_present;
        req.iommu_flags       = r.iommu_flags;
        req.supported_widths  = r.supported_widths;
        req.max_address_width = r.max_address_width;
        req.superpage_support = r.superpage_support;
        req.handle_in         = r.handle_in;
        req.valid             = 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_PT_ID)
            pt_id = value;
    endtask

    task automatic directed_items();
        req_t r;
        logic [IN_ADDR_W-1:0] a;
        a = roots[0];
        send(base_item(OP_ALLOC, a));
        send(base_item(OP_ALLOC, a));
        send(base_item(OP_ALLOC, '0));
        send(base_item(OP_ALLOC, a | 52'h800));
        r = base_item(OP_ALLOC, roots[1]); r.iommu_present = 1'b0; send(r);
        r = base_item(OP_ALLOC, roots[1]); r.width_code = 3'd7; send(r);
        // first level at a 12-bit limit leaves 11 bits
        r = base_item(OP_ALLOC, roots[1]); r.first_level = 1'b1; r.max_address_width = 7'd12;
        send(r);
        r = base_item(OP_GET, a); r.domain_id = pt_id; send(r);
        r.supported_widths = 5'b00000; send(r);
        send(base_item(OP_GET, a));
        r = base_item(OP_GET, a); r.iommu_flags = 6'b001111; send(r);
        send(base_item(OP_GET, roots[2]));
        r = base_item(OP_PUT, a); r.handle_in = 7'd64; send(r);
        r.handle_in = 7'd127; send(r);
        r.handle_in = 7'd0; send(r);
        send(base_item(OP_FREE, a));
        send(r);
        send(base_item(OP_FREE, a));
        r.handle_in = 7'd5; send(r);
        send(base_item(OP_ALLOC, 52'hFFFFF_FFFF_F000));
        send(base_item(OP_GET, 52'hFFFFF_FFFF_F001));
        r = base_item(OP_ALLOC, roots[3]); r.first_level = 1'b1; r.iommu_flags = 6'b011011;
        send(r);
        send(base_item(OP_FREE, roots[3]));
    endtask

    initial
    begin
        logic [2:0]  agaws[5] = '{3'd2, 3'd0, 3'd4, 3'd3, 3'd1};
        logic [15:0] ids[5]   = '{16'd1, 16'd0, 16'hFFFF, 16'h1234, 16'h00FF};
        req.valid = 1'b0;
        req.operation = OP_ALLOC;
        req.root_address = '0;
        req.domain_id = '0;
        req.width_code = '0;
        req.first_level = 1'b0;
        req.iommu_present = 1'b0;
        req.iommu_flags = '0;
        req.supported_widths = '0;
        req.max_address_width = '0;
        req.superpage_support = '0;
        req.handle_in = '0;
        rsp.ready = 1'b0;
        for (int i = 0; i < ROOT_POOL; i++)
            roots[i] = {20'($urandom()), 20'($urandom() | 1), 12'h000};
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        directed_items();
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_reg(CFG_PT_AGAW, 16'(agaws[ph]));
            write_reg(CFG_PT_ID, ids[ph]);
            for (int n = 0; n < 150; n++)
            begin
                calm = (ph == 4 && n >= 100);
                send(random_item());
            end
        end
        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        if (errors == 0)
            $display("iommu_domain_table_unit verification clean");
        else
            $display("iommu_domain_table_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
design/idt_pkg.sv
design/idt_req_if.sv
design/idt_rsp_if.sv
design/idt_ram.sv
design/idt_ctrl.sv
design/iommu_domain_table_unit.sv
dv/idt_domain_checker.sv
dv/tb_iommu_domain_table_unit.sv
